// ===== rtl/m1sh_pkg.sv =====
// shared types and constants for the murmur1 stream hash
package m1sh_pkg;

  localparam logic [31:0] MIX_MULT    = 32'hc6a4a793;
  localparam int          WORD_SHIFT  = 16;
  localparam int          FIN_SHIFT_A = 10;
  localparam int          FIN_SHIFT_B = 17;

  typedef enum logic [2:0] {
    OP_MUL = 3'b001,
    OP_ADD = 3'b010,
    OP_XS  = 3'b100
  } alu_op_t;

  typedef enum logic [3:0] {
    PH_LOAD  = 4'b0001,
    PH_MIX   = 4'b0010,
    PH_FIN_A = 4'b0100,
    PH_FIN_B = 4'b1000
  } phase_t;

  typedef struct packed {
    alu_op_t op;
    phase_t  phase;
  } alu_ctrl_t;

endpackage

// ===== rtl/m1sh_alu.sv =====
// shared multiply, add and xor-shift unit for the running hash
module m1sh_alu (
  input  m1sh_pkg::alu_ctrl_t ctrl,
  input  logic [31:0]         acc,
  input  logic [31:0]         addend,
  output logic [31:0]         result
);

  logic [31:0] shifted;

  always_comb begin
    case (ctrl.phase)
      m1sh_pkg::PH_FIN_A: shifted = acc >> m1sh_pkg::FIN_SHIFT_A;
      m1sh_pkg::PH_FIN_B: shifted = acc >> m1sh_pkg::FIN_SHIFT_B;
      default:            shifted = acc >> m1sh_pkg::WORD_SHIFT;
    endcase
  end

  always_comb begin
    case (ctrl.op)
      m1sh_pkg::OP_MUL: result = acc * m1sh_pkg::MIX_MULT;
      m1sh_pkg::OP_ADD: result = acc + addend;
      m1sh_pkg::OP_XS:  result = acc ^ shifted;
      default:          result = acc;
    endcase
  end

endmodule

// ===== rtl/murmur1_stream_hash.sv =====
// top level of the streaming 32-bit murmur1 hash
// One word is taken at a time and the block stalls its input until that word is
// done. A single shared unit (one 32x32 multiply, add, xor-shift) steps the
// running hash one operation per cycle: a first word costs one extra multiply
// to load the start value from message_length, a word with valid bytes costs add,
// multiply and xor-shift, and a last word adds four finalize steps plus a done
// step that moves the hash into the output register; that step repeats while
// the output register still holds an earlier hash that has not been taken.
// A full middle word therefore passes through the idle, add, multiply and xor-shift
// states; a word with no valid bytes that is neither first nor last stays in idle.
module murmur1_stream_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        first,
  input  logic [31:0] message_length,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_value
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADD  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_XS   = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t              state, state_next;
  m1sh_pkg::phase_t    phase, phase_next;
  m1sh_pkg::alu_ctrl_t ctrl;
  logic [31:0]         acc, acc_next;
  logic [31:0]         word;
  logic                has_bytes;
  logic                is_last;
  logic [31:0]         alu_result;
  logic [31:0]         masked_word;
  logic                in_accept;
  logic                out_load;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = rst || (state != ST_IDLE);
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    case (valid_bytes)
      3'd1:    masked_word = {24'd0, data_word[7:0]};
      3'd2:    masked_word = {16'd0, data_word[15:0]};
      3'd3:    masked_word = {8'd0, data_word[23:0]};
      default: masked_word = data_word;
    endcase
  end

  always_comb begin
    ctrl.phase = phase;
    case (state)
      ST_ADD:  ctrl.op = m1sh_pkg::OP_ADD;
      ST_XS:   ctrl.op = m1sh_pkg::OP_XS;
      default: ctrl.op = m1sh_pkg::OP_MUL;
    endcase
  end

  m1sh_alu u_alu (
    .ctrl   (ctrl),
    .acc    (acc),
    .addend (word),
    .result (alu_result)
  );

  always_comb begin
    state_next = state;
    phase_next = phase;
    acc_next   = acc;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (first) begin
            acc_next   = message_length;
            phase_next = m1sh_pkg::PH_LOAD;
            state_next = ST_MUL;
          end else if (valid_bytes != 3'd0) begin
            phase_next = m1sh_pkg::PH_MIX;
            state_next = ST_ADD;
          end else if (last) begin
            phase_next = m1sh_pkg::PH_FIN_A;
            state_next = ST_MUL;
          end
        end
      end
      ST_ADD: begin
        acc_next   = alu_result;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        acc_next = alu_result;
        if (phase == m1sh_pkg::PH_LOAD) begin
          if (has_bytes) begin
            phase_next = m1sh_pkg::PH_MIX;
            state_next = ST_ADD;
          end else if (is_last) begin
            phase_next = m1sh_pkg::PH_FIN_A;
            state_next = ST_MUL;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_XS;
        end
      end
      ST_XS: begin
        acc_next = alu_result;
        case (phase)
          m1sh_pkg::PH_MIX: begin
            if (is_last) begin
              phase_next = m1sh_pkg::PH_FIN_A;
              state_next = ST_MUL;
            end else begin
              state_next = ST_IDLE;
            end
          end
          m1sh_pkg::PH_FIN_A: begin
            phase_next = m1sh_pkg::PH_FIN_B;
            state_next = ST_MUL;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= m1sh_pkg::PH_MIX;
      acc   <= 32'd0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      acc   <= acc_next;
    end
  end

  // word payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      word      <= masked_word;
      has_bytes <= (valid_bytes != 3'd0);
      is_last   <= last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hash_value <= acc;
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(hash_value)))
    else $error("stalled hash changed");

  a_empty_word_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !first && valid_bytes == 3'd0 && !last) |=> !in_stall)
    else $error("empty middle word did not return to idle");

  a_last_word_busy: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last) |=> (in_stall && state != ST_DONE))
    else $error("last word finished too early");

  a_first_loads_length: assert property (@(posedge clk) disable iff (rst)
    (in_accept && first) |=> (acc == $past(message_length)))
    else $error("start value not loaded from length");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the streaming murmur1 hash with random flow control
module testbench;

  localparam int TOTAL_WORDS  = 850;
  localparam int QUIET_FROM   = 750;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic        first;
    logic [31:0] msg_len;
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } word_item_t;

  typedef struct packed {
    word_item_t  item;
    logic        known;
    logic [31:0] hash;
  } directed_row_t;

  logic        clk;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic        first          = 1'b0;
  logic [31:0] message_length = '0;
  logic [31:0] data_word      = '0;
  logic [2:0]  valid_bytes    = '0;
  logic        last           = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [31:0] hash_value;

  logic [31:0]   hash_state = '0;
  logic [31:0]   expected_hashes[$];
  logic [31:0]   oldest_hash;
  directed_row_t directed_rows[$];
  int            error_count = 0;
  int            words_sent  = 0;
  int            stall_left  = 0;
  int            cycle_count;
  bit            quiet       = 1'b0;

  murmur1_stream_hash i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .first          (first),
    .message_length (message_length),
    .data_word      (data_word),
    .valid_bytes    (valid_bytes),
    .last           (last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hash_value     (hash_value)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [31:0] mul_mix(input logic [31:0] a);
    logic [31:0] p;
    p = a * m1sh_pkg::MIX_MULT;
    return p;
  endfunction

  // steps the hash model by one word, returns 1 when a hash is finished
  function automatic bit advance_hash(input word_item_t w, output logic [31:0] digest);
    logic [31:0] h;
    logic [31:0] mask;
    int          n;
    n = (w.nbytes > 3'd4) ? 4 : int'(w.nbytes);
    if (w.first) hash_state = mul_mix(w.msg_len);
    h = hash_state;
    if (n != 0) begin
      mask = 32'hffffffff >> (8 * (4 - n));
      h = mul_mix(h + (w.data & mask));
      h = h ^ (h >> m1sh_pkg::WORD_SHIFT);
    end
    if (w.last) begin
      h = mul_mix(h);
      h = h ^ (h >> m1sh_pkg::FIN_SHIFT_A);
      h = mul_mix(h);
      h = h ^ (h >> m1sh_pkg::FIN_SHIFT_B);
    end
    hash_state = h;
    digest = h;
    return w.last;
  endfunction

  function automatic void add_row(input logic f, input logic [31:0] len, input logic [31:0] data,
                                  input logic [2:0] nb, input logic l, input logic known,
                                  input logic [31:0] hash);
    directed_row_t r;
    r.item = '{first: f, msg_len: len, data: data, nbytes: nb, last: l};
    r.known = known;
    r.hash = hash;
    directed_rows.push_back(r);
  endfunction

  task automatic send_word(input word_item_t w, input logic known, input logic [31:0] known_hash);
    logic [31:0] digest;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    first          <= w.first;
    message_length <= w.msg_len;
    data_word      <= w.data;
    valid_bytes    <= w.nbytes;
    last           <= w.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (advance_hash(w, digest)) expected_hashes.push_back(known ? known_hash : digest);
    words_sent++;
  endtask

  task automatic wait_for_hashes();
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random stall bursts on the result side
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_hashes.size() == 0) begin
        $display("%0t: unexpected hash_value: expected none, actual %h", $time, hash_value);
        error_count++;
      end else begin
        oldest_hash = expected_hashes.pop_front();
        if (hash_value !== oldest_hash) begin
          $display("%0t: hash_value mismatch: expected %h, actual %h",
                   $time, oldest_hash, hash_value);
          error_count++;
        end
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    word_item_t w;
    int         pick;
    int         msg_bytes;
    int         full_words;
    int         tail;
    int         run_len;
    bit         close_on_word;

    // words before any first, empty messages, zero data
    add_row(1'b0, 32'hffffffff, 32'h00000000, 3'd4, 1'b0, 1'b0, 32'h0);
    add_row(1'b0, 32'h00000000, 32'hffffffff, 3'd0, 1'b1, 1'b1, 32'h0);
    add_row(1'b1, 32'h00000000, 32'h00000000, 3'd0, 1'b1, 1'b1, 32'h0);
    add_row(1'b1, 32'h00000000, 32'h00000000, 3'd4, 1'b1, 1'b1, 32'h0);
    add_row(1'b1, 32'h00000004, 32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0);
    // partial word in the middle, then zero-byte finish
    add_row(1'b1, 32'hffffffff, 32'hffffffff, 3'd4, 1'b0, 1'b0, 32'h0);
    add_row(1'b0, 32'h00000000, 32'h00000000, 3'd4, 1'b0, 1'b0, 32'h0);
    add_row(1'b0, 32'h00000000, 32'h80ffffff, 3'd3, 1'b0, 1'b0, 32'h0);
    add_row(1'b0, 32'h00000000, 32'h00000000, 3'd0, 1'b1, 1'b0, 32'h0);
    // oversized byte counts
    add_row(1'b1, 32'h00000008, 32'h12345678, 3'd5, 1'b0, 1'b0, 32'h0);
    add_row(1'b0, 32'h00000000, 32'hdeadbeef, 3'd7, 1'b1, 1'b0, 32'h0);
    add_row(1'b1, 32'h00000004, 32'ha5a5a5a5, 3'd6, 1'b1, 1'b0, 32'h0);
    // tails of 1, 2 and 3 bytes
    add_row(1'b1, 32'h00000005, 32'h00000001, 3'd4, 1'b0, 1'b0, 32'h0);
    add_row(1'b0, 32'h00000000, 32'hffffffff, 3'd1, 1'b1, 1'b0, 32'h0);
    add_row(1'b1, 32'h00000006, 32'h7fffffff, 3'd4, 1'b0, 1'b0, 32'h0);
    add_row(1'b0, 32'h00000000, 32'hffffffff, 3'd2, 1'b1, 1'b0, 32'h0);
    add_row(1'b1, 32'h00000007, 32'hfffffffe, 3'd4, 1'b0, 1'b0, 32'h0);
    add_row(1'b0, 32'h00000000, 32'hffffffff, 3'd3, 1'b1, 1'b0, 32'h0);
    // continue from a finished hash without first
    add_row(1'b0, 32'h00000000, 32'h55555555, 3'd4, 1'b1, 1'b0, 32'h0);
    add_row(1'b1, 32'h80000000, 32'haaaaaaaa, 3'd0, 1'b1, 1'b0, 32'h0);
    add_row(1'b1, 32'h00000003, 32'h00ffffff, 3'd3, 1'b1, 1'b0, 32'h0);
    // whole-word message closed on its final word
    add_row(1'b1, 32'h0000000c, 32'h11111111, 3'd4, 1'b0, 1'b0, 32'h0);
    add_row(1'b0, 32'h00000000, 32'h22222222, 3'd4, 1'b0, 1'b0, 32'h0);
    add_row(1'b0, 32'h00000000, 32'h33333333, 3'd4, 1'b1, 1'b0, 32'h0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      send_word(directed_rows[k].item, directed_rows[k].known, directed_rows[k].hash);
    wait_for_hashes();

    while (words_sent < TOTAL_WORDS) begin
      quiet <= (words_sent >= QUIET_FROM);
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        // well-formed message
        msg_bytes = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
        full_words = msg_bytes / 4;
        tail = msg_bytes % 4;
        close_on_word = (tail == 0) && (full_words != 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < full_words; i++) begin
          w.first   = (i == 0);
          w.msg_len = (i == 0 && $urandom_range(0, 9) != 0) ? 32'(msg_bytes) : $urandom;
          w.data    = $urandom;
          w.nbytes  = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
          w.last    = close_on_word && (i == full_words - 1);
          send_word(w, 1'b0, '0);
        end
        if (!close_on_word) begin
          w.first   = (full_words == 0);
          w.msg_len = (full_words == 0 && $urandom_range(0, 9) != 0) ? 32'(msg_bytes) : $urandom;
          w.data    = $urandom;
          w.nbytes  = 3'(tail);
          w.last    = 1'b1;
          send_word(w, 1'b0, '0);
        end
      end else if (pick < 90) begin
        // noise word
        w.first   = 1'($urandom_range(0, 1));
        w.msg_len = $urandom;
        w.data    = $urandom;
        w.nbytes  = 3'($urandom_range(0, 7));
        w.last    = ($urandom_range(0, 3) == 0);
        send_word(w, 1'b0, '0);
      end else begin
        // broken sequence
        run_len = $urandom_range(1, 6);
        for (int i = 0; i < run_len; i++) begin
          w.first   = (i == 0);
          w.msg_len = $urandom;
          w.data    = $urandom;
          w.nbytes  = 3'($urandom_range(0, 7));
          w.last    = (i == run_len - 1) && ($urandom_range(0, 1) == 1);
          send_word(w, 1'b0, '0);
        end
      end
      if ($urandom_range(0, 39) == 0) wait_for_hashes();
    end

    wait_for_hashes();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
